FILE: rtl/assert_macros.svh
// Assertion macros for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FFRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define FFRA_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ffra_pkg.sv
// Types and constants of the first-fit region allocator.
`default_nettype none
package ffra_pkg;
  localparam int OFF_W  = 20;
  localparam int SIZE_W = 21;
  localparam int IDX_W  = 8;

  localparam logic [SIZE_W-1:0] ARENA_MIN   = 21'd64;
  localparam logic [SIZE_W-1:0] ARENA_MAX   = 21'd1048576;
  localparam logic [SIZE_W-1:0] ARENA_RESET = 21'd65536;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0] req_size;
    logic [OFF_W-1:0]  free_addr;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [OFF_W-1:0]  block_addr;
    logic [SIZE_W-1:0] block_size;
    logic [SIZE_W-1:0] used_bytes;
  } out_t;

  typedef struct packed {
    logic [OFF_W-1:0]  start;
    logic [SIZE_W-1:0] size;
    logic              used;
  } ent_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    ent_t             wr_ent;
    logic             ins_en;
    logic [IDX_W-1:0] ins_idx;
    ent_t             ins_ent;
    logic             rm_en;
    logic [IDX_W-1:0] rm_idx;
  } tbl_cmd_t;
endpackage
`default_nettype wire

FILE: rtl/ffra_table.sv
// Address-ordered region table with single read port, insert and remove shifts.
`default_nettype none
module ffra_table #(
  parameter int MAX_REGIONS  = 16,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               init_en,
  input  wire logic [ffra_pkg::SIZE_W-1:0]        init_size,
  input  wire logic [$clog2(MAX_REGIONS)-1:0]     rd_idx,
  output ffra_pkg::ent_t                          rd_ent,
  input  wire ffra_pkg::tbl_cmd_t                 cmd,
  output logic [$clog2(MAX_REGIONS+1)-1:0]        count
);
  import ffra_pkg::*;

  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam logic [OFF_W-1:0]  HB_OFF  = OFF_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] HB_SIZE = SIZE_W'(HEADER_BYTES);

  ent_t          ent_r   [MAX_REGIONS];
  ent_t          ent_nxt [MAX_REGIONS];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ins_i, rm_i;

  assign ins_i = CW'(cmd.ins_idx);
  assign rm_i  = CW'(cmd.rm_idx);

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (init_en) begin
      ent_nxt[0] = '{start: HB_OFF, size: init_size, used: 1'b0};
      cnt_nxt    = CW'(1);
    end else begin
      for (int k = 1; k < MAX_REGIONS; k++) begin
        if (cmd.ins_en && CW'(k) > ins_i && CW'(k) <= cnt_r) begin
          ent_nxt[k] = ent_r[k-1];
        end
      end
      for (int k = 0; k < MAX_REGIONS - 1; k++) begin
        if (cmd.rm_en && CW'(k) >= rm_i && CW'(k + 1) < cnt_r) begin
          ent_nxt[k] = ent_r[k+1];
        end
      end
      if (cmd.ins_en) begin
        ent_nxt[cmd.ins_idx[IW-1:0]] = cmd.ins_ent;
        cnt_nxt = cnt_r + CW'(1);
      end
      if (cmd.rm_en && cnt_r > CW'(1)) begin
        cnt_nxt = cnt_r - CW'(1);
      end
      if (cmd.wr_en) begin
        ent_nxt[cmd.wr_idx[IW-1:0]] = cmd.wr_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= CW'(1);
      ent_r[0] <= '{start: HB_OFF, size: ARENA_RESET - HB_SIZE, used: 1'b0};
    end else begin
      cnt_r <= cnt_nxt;
      ent_r <= ent_nxt;
    end
  end

  assign rd_ent = ent_r[rd_idx];
  assign count  = cnt_r;
endmodule
`default_nettype wire

FILE: rtl/first_fit_region_allocator_top.sv
// Top level of the first-fit region allocator with coalescing.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    ffra_pkg::in_t
//   out_     output     out_valid/out_ready  ffra_pkg::out_t
//   cfg_     input      cfg_we (no wait)     arena_size, 21 bits
//
// An allocate is accepted, scans the entries and then writes the chosen entry,
// splitting off any remainder; a free is accepted, scans the entries, marks the
// entry free and takes up to 3 merge steps (S_NEXT, S_PREV, S_PREV2). The scan
// reads one table entry per cycle through the single table read port. The
// result waits in an output register; a new transaction is taken once it has
// been delivered. Synchronous reset leaves one free region.
`default_nettype none
module first_fit_region_allocator_top #(
  parameter int MAX_REGIONS  = 16,
  parameter int HEADER_BYTES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire ffra_pkg::in_t               in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ffra_pkg::out_t                   out_data,
  input  wire logic                        cfg_we,
  input  wire logic [ffra_pkg::SIZE_W-1:0] cfg_wdata
);
  import ffra_pkg::*;
  `include "assert_macros.svh"

  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam logic [SIZE_W-1:0] HB = SIZE_W'(HEADER_BYTES);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_ALLOC = 7'b0000100,
    S_FREE  = 7'b0001000,
    S_NEXT  = 7'b0010000,
    S_PREV  = 7'b0100000,
    S_PREV2 = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  in_t               req_r, req_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     base_r, base_nxt;
  logic [SIZE_W-1:0] sz_r, sz_nxt;
  logic [OFF_W-1:0]  st_r, st_nxt;
  logic [SIZE_W-1:0] used_r, used_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              res_r, res_nxt;

  ent_t              e;
  tbl_cmd_t          cmd;
  logic [CW-1:0]     cnt;
  logic              init_en;
  logic [SIZE_W-1:0] arena_v, init_size;
  logic              last, hit;
  logic [SIZE_W-1:0] left, gsz, merged;
  logic              split;
  logic [SIZE_W:0]   give;

  assign init_en = cfg_we;
  assign arena_v = (cfg_wdata < ARENA_MIN) ? ARENA_MIN :
                   (cfg_wdata > ARENA_MAX) ? ARENA_MAX : cfg_wdata;
  assign init_size = arena_v - HB;

  ffra_table #(
    .MAX_REGIONS (MAX_REGIONS),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .init_en  (init_en),
    .init_size(init_size),
    .rd_idx   (idx_r),
    .rd_ent   (e),
    .cmd      (cmd),
    .count    (cnt)
  );

  assign last = (CW'(idx_r) + CW'(1)) >= cnt;
  assign hit  = (req_r.op == OP_ALLOC) ? (!e.used && e.size >= req_r.req_size)
                                       : (e.used && e.start == req_r.free_addr);
  assign left   = e.size - req_r.req_size;
  assign split  = (left > HB) && (cnt < CW'(MAX_REGIONS));
  assign gsz    = split ? req_r.req_size : e.size;
  assign give   = {1'b0, e.size} + {1'b0, HB};
  assign merged = (state_r == S_NEXT) ? (sz_r + e.size + HB) : (e.size + sz_r + HB);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    base_nxt      = base_r;
    sz_nxt        = sz_r;
    st_nxt        = st_r;
    used_nxt      = used_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          req_nxt   = in_data;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = (req_r.op == OP_ALLOC) ? S_ALLOC : S_FREE;
        end else if (last) begin
          res_nxt.status     = (req_r.op == OP_ALLOC) ? ST_NO_SPACE : ST_NOT_FOUND;
          res_nxt.block_addr = (req_r.op == OP_ALLOC) ? '0 : req_r.free_addr;
          res_nxt.block_size = '0;
          res_nxt.used_bytes = used_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_ALLOC: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_idx = IDX_W'(idx_r);
        cmd.wr_ent = '{start: e.start, size: gsz, used: 1'b1};
        if (split) begin
          cmd.ins_en  = 1'b1;
          cmd.ins_idx = IDX_W'(idx_r) + IDX_W'(1);
          cmd.ins_ent = '{start: e.start + req_r.req_size[OFF_W-1:0] + HB[OFF_W-1:0],
                          size: left - HB, used: 1'b0};
        end
        used_nxt           = used_r + HB + gsz;
        res_nxt.status     = ST_OK;
        res_nxt.block_addr = e.start;
        res_nxt.block_size = gsz;
        res_nxt.used_bytes = used_r + HB + gsz;
        out_valid_nxt      = 1'b1;
        state_nxt          = S_IDLE;
      end
      S_FREE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_idx = IDX_W'(idx_r);
        cmd.wr_ent = '{start: e.start, size: e.size, used: 1'b0};
        used_nxt   = ({1'b0, used_r} > give) ? (used_r - give[SIZE_W-1:0]) : '0;
        res_nxt.status     = ST_OK;
        res_nxt.block_addr = req_r.free_addr;
        res_nxt.block_size = e.size;
        sz_nxt   = e.size;
        st_nxt   = e.start;
        base_nxt = idx_r;
        if (last) begin
          state_nxt = S_PREV;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (!e.used) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_idx = IDX_W'(base_r);
          cmd.wr_ent = '{start: st_r, size: merged, used: 1'b0};
          cmd.rm_en  = 1'b1;
          cmd.rm_idx = IDX_W'(idx_r);
          sz_nxt     = merged;
        end
        idx_nxt   = base_r;
        state_nxt = S_PREV;
      end
      S_PREV: begin
        if (base_r == '0) begin
          res_nxt.used_bytes = used_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end else begin
          idx_nxt   = base_r - IW'(1);
          state_nxt = S_PREV2;
        end
      end
      S_PREV2: begin
        if (!e.used) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_idx = IDX_W'(idx_r);
          cmd.wr_ent = '{start: e.start, size: merged, used: 1'b0};
          cmd.rm_en  = 1'b1;
          cmd.rm_idx = IDX_W'(base_r);
        end
        res_nxt.used_bytes = used_r;
        out_valid_nxt      = 1'b1;
        state_nxt          = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_we) begin
      used_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    idx_r  <= idx_nxt;
    base_r <= base_nxt;
    sz_r   <= sz_nxt;
    st_r   <= st_nxt;
    res_r  <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  `FFRA_ASSERT(a_count_range, (cnt != '0) && (cnt <= CW'(MAX_REGIONS)), "table count out of range")
  `FFRA_ASSERT_NEXT(a_accept_scan, in_valid && in_ready, state_r == S_SCAN, "accept did not start scan")
  `FFRA_ASSERT(a_scan_idx, (state_r == S_SCAN) |-> (CW'(idx_r) < cnt), "scan index past table end")
  `FFRA_ASSERT_NEXT(a_alloc_done, state_r == S_ALLOC, out_valid_r && state_r == S_IDLE, "allocate did not finish")
endmodule
`default_nettype wire

FILE: sim/tb_first_fit_region_allocator_top.sv
// Testbench for the first-fit region allocator: a self-checking allocation-table predictor.
`default_nettype none
module tb_first_fit_region_allocator_top;
  import ffra_pkg::*;

  localparam int NREG = 16;
  localparam int HDR = 16;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  first_fit_region_allocator_top #(.MAX_REGIONS(NREG), .HEADER_BYTES(HDR)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [SIZE_W-1:0] arena;
  logic [OFF_W-1:0] reg_start [NREG];
  logic [SIZE_W-1:0] reg_size [NREG];
  logic reg_used [NREG];
  int reg_cnt;
  logic [SIZE_W-1:0] used_sum;

  out_t pending_results[$];
  int mismatches;
  int results_seen;
  int no_space_seen, not_found_seen;
  bit hold_off;
  bit burst_mode;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Timeout: %0d results still expected", pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic void table_init();
    for (int k = 0; k < NREG; k++) begin
      reg_start[k] = '0;
      reg_size[k] = '0;
      reg_used[k] = 1'b0;
    end
    reg_start[0] = OFF_W'(HDR);
    reg_size[0] = (arena > HDR) ? arena - SIZE_W'(HDR) : '0;
    reg_cnt = 1;
    used_sum = '0;
  endfunction

  function automatic void table_remove(int idx);
    for (int k = idx; k + 1 < reg_cnt && k + 1 < NREG; k++) begin
      reg_start[k] = reg_start[k+1];
      reg_size[k] = reg_size[k+1];
      reg_used[k] = reg_used[k+1];
    end
    if (reg_cnt > 1) reg_cnt--;
  endfunction

  function automatic void table_insert(int idx, logic [31:0] st, logic [31:0] sz);
    for (int k = reg_cnt; k > idx; k--) begin
      reg_start[k] = reg_start[k-1];
      reg_size[k] = reg_size[k-1];
      reg_used[k] = reg_used[k-1];
    end
    reg_start[idx] = st[OFF_W-1:0];
    reg_size[idx] = sz[SIZE_W-1:0];
    reg_used[idx] = 1'b0;
    reg_cnt++;
  endfunction

  function automatic out_t predict_region_op(in_t req);
    out_t r;
    int i;
    int n;
    bit found;
    logic [31:0] left;
    logic [31:0] give;
    r = '0;
    n = (reg_cnt > NREG) ? NREG : reg_cnt;
    found = 1'b0;
    if (req.op == OP_ALLOC) begin
      for (i = 0; i < n; i++) begin
        if (!reg_used[i] && reg_size[i] >= req.req_size) begin
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        r.status = ST_NO_SPACE;
      end else begin
        left = 32'(reg_size[i]) - 32'(req.req_size);
        reg_used[i] = 1'b1;
        if (left > HDR && reg_cnt < NREG) begin
          table_insert(i + 1, 32'(reg_start[i]) + 32'(req.req_size) + HDR, left - HDR);
          reg_size[i] = req.req_size;
        end
        used_sum = SIZE_W'(32'(used_sum) + HDR + 32'(reg_size[i]));
        r.status = ST_OK;
        r.block_addr = reg_start[i];
        r.block_size = reg_size[i];
      end
    end else begin
      r.block_addr = req.free_addr;
      for (i = 0; i < n; i++) begin
        if (reg_used[i] && reg_start[i] == req.free_addr) begin
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        r.status = ST_NOT_FOUND;
      end else begin
        give = 32'(reg_size[i]) + HDR;
        r.status = ST_OK;
        r.block_size = reg_size[i];
        used_sum = (32'(used_sum) > give) ? SIZE_W'(32'(used_sum) - give) : '0;
        reg_used[i] = 1'b0;
        if (i + 1 < n && !reg_used[i+1]) begin
          reg_size[i] = SIZE_W'(32'(reg_size[i]) + 32'(reg_size[i+1]) + HDR);
          table_remove(i + 1);
        end
        if (i > 0 && !reg_used[i-1]) begin
          reg_size[i-1] = SIZE_W'(32'(reg_size[i-1]) + 32'(reg_size[i]) + HDR);
          table_remove(i);
        end
      end
    end
    r.used_bytes = used_sum;
    return r;
  endfunction

  // drop valid only while idling; drain drops it at the end
  task automatic send_request(logic op, logic [SIZE_W-1:0] sz, logic [OFF_W-1:0] addr);
    in_t req;
    req.op = op;
    req.req_size = sz;
    req.free_addr = addr;
    while (!burst_mode && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    pending_results.push_back(predict_region_op(req));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_alloc(logic [SIZE_W-1:0] sz);
    send_request(OP_ALLOC, sz, OFF_W'($urandom));
  endtask

  task automatic send_free(logic [OFF_W-1:0] addr);
    send_request(OP_FREE, SIZE_W'($urandom), addr);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_arena(logic [SIZE_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    arena = (v < ARENA_MIN) ? ARENA_MIN : (v > ARENA_MAX) ? ARENA_MAX : v;
    table_init();
  endtask

  // pick the start of a used region, or sometimes a bogus one
  function automatic logic [OFF_W-1:0] pick_free_addr();
    int idx[$];
    for (int k = 0; k < reg_cnt && k < NREG; k++)
      if (reg_used[k]) idx.push_back(k);
    if (idx.size() == 0 || $urandom_range(9) == 0) begin
      if ($urandom_range(1) == 1 && reg_cnt > 0)
        return reg_start[$urandom_range(reg_cnt - 1)];
      return OFF_W'($urandom);
    end
    return reg_start[idx[$urandom_range(idx.size() - 1)]];
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return SIZE_W'($urandom_range(arena / 8));
    if (r < 85) return SIZE_W'($urandom_range(HDR * 2));
    if (r < 95) return SIZE_W'($urandom_range(arena));
    return SIZE_W'($urandom);
  endfunction

  task automatic random_traffic(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(1) == 0) send_alloc(pick_size());
      else send_free(pick_free_addr());
    end
  endtask

  task automatic test_directed();
    write_arena(ARENA_RESET);
    send_alloc(21'd0);
    send_alloc(21'd100);
    send_alloc(21'h1FFFFF);
    send_free(OFF_W'(HDR));
    send_free(20'hFFFFF);
    send_free(OFF_W'(HDR));
    send_alloc(21'd200);
    for (int k = 0; k < 16; k++) send_alloc(21'd64);
    send_free(pick_free_addr());
    send_free(pick_free_addr());
    write_arena(21'd10);
    send_alloc(21'd48);
    send_alloc(21'd0);
    write_arena(21'h1FFFFF);
    send_alloc(21'd1048560);
    send_free(OFF_W'(HDR));
    send_alloc(21'd1048576);
  endtask

  task automatic test_random_arenas();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_arena(ARENA_MIN);
        1: write_arena(ARENA_MAX);
        2: write_arena(21'd1000);
        default: write_arena(SIZE_W'($urandom_range(64, 1 << 20)));
      endcase
      random_traffic(220);
    end
  endtask

  task automatic test_burst();
    write_arena(21'd4096);
    burst_mode = 1'b1;
    random_traffic(150);
    burst_mode = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    random_traffic(6);
    hold_off = 1'b0;
    drain();
    random_traffic(40);
  endtask

  // hold out_ready low for a long stretch once hold_off is set, else drive it randomly (always high in burst mode)
  initial begin
    int stall_cycles;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        stall_cycles = 0;
        while (stall_cycles < 200) begin
          @(posedge clk);
          stall_cycles++;
        end
        out_ready <= 1'b1;
        while (hold_off) @(posedge clk);
      end else begin
        out_ready <= burst_mode || ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.status == ST_NO_SPACE) no_space_seen++;
        if (exp_r.status == ST_NOT_FOUND) not_found_seen++;
        if (out_data.status !== exp_r.status || out_data.block_addr !== exp_r.block_addr ||
            out_data.block_size !== exp_r.block_size ||
            out_data.used_bytes !== exp_r.used_bytes) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected st=%0d addr=%0d size=%0d used=%0d, got st=%0d addr=%0d size=%0d used=%0d",
                     exp_r.status, exp_r.block_addr, exp_r.block_size, exp_r.used_bytes,
                     out_data.status, out_data.block_addr, out_data.block_size,
                     out_data.used_bytes);
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    hold_off = 1'b0;
    burst_mode = 1'b0;
    mismatches = 0;
    results_seen = 0;
    no_space_seen = 0;
    not_found_seen = 0;
    arena = ARENA_RESET;
    table_init();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_arenas();
    test_burst();
    test_backpressure();
    drain();
    if (pending_results.size() != 0) mismatches++;
    $display("Covered %0d results over arenas 64..1048576: %0d no-space, %0d not-found",
             results_seen, no_space_seen, not_found_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
